[hdl/bilinear_sample_alpha_blend_core_macros.svh]
// Assertion macros shared by the bilinear sample and alpha blend RTL.
`ifndef BILINEAR_SAMPLE_ALPHA_BLEND_CORE_MACROS_SVH
`define BILINEAR_SAMPLE_ALPHA_BLEND_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BSAB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BSAB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BSAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/bsab_pkg.sv]
// Types and constants for the bilinear sample and alpha blend core.
package bsab_pkg;

	localparam int NUM_CORNERS = 4;
	localparam int NUM_LANES   = 4;
	localparam int NUM_COLORS  = 3;
	localparam int LANE_ALPHA  = 3;

	localparam int CHAN_W   = 8;
	localparam int PIXEL_W  = 32;
	localparam int WEIGHT_W = 17;
	localparam int PROD_W   = 24;
	localparam int DPROD_W  = 16;
	localparam int QMUL_W   = 32;

	// Corner positions in the packed corner arrays.
	localparam int CORNER_TL = 0;
	localparam int CORNER_TR = 1;
	localparam int CORNER_BL = 2;
	localparam int CORNER_BR = 3;

	// Full-scale fraction weight and the opaque channel value.
	localparam logic [8:0]        WEIGHT_ONE  = 9'd256;
	localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hFF;
	localparam logic [WEIGHT_W+1:0] WEIGHT_SUM = 19'd65536;

	// Division by 255 of a 16-bit value: (x * 0x8081) >> 23 is exact.
	localparam logic [15:0] RECIP_255   = 16'h8081;
	localparam int          RECIP_SHIFT = 23;

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [PIXEL_W-1:0]  pixel_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [DPROD_W-1:0]  dprod_t;
	typedef logic [QMUL_W-1:0]   qmul_t;

	// Outcome of the blend decision for one pixel.
	typedef enum logic [1:0] {
		MODE_COPY,
		MODE_KEEP,
		MODE_BLEND
	} blend_mode_t;

endpackage

[hdl/bilinear_sample_alpha_blend_core.sv]
// Bilinear sampler with premultiplied alpha "over" blend, six-stage pipeline.
//
// Input channel: in_valid / in_stall carry one request per destination pixel:
// the four neighboring BGRA source pixels, the 8-bit fractions frac_x and
// frac_y, and the current destination pixel. A request is taken at a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry out_pixel and write_enable.
// When write_enable is low the destination is to be left as it is and
// out_pixel repeats dest_pixel.
// Configuration: cfg_wr_en writes cfg_wr_data into the blend enable register;
// write it only while no request is in flight.
// One request per cycle is sustained while in_stall is low; the stages are
// weight multiply, corner products, lane sums, destination scaling,
// reciprocal multiply for the divide by 255, and the final add, saturate
// and select in the output register.
// Each stage holds only while the stage after it is full and held, so empty
// slots are filled during a stall and the output register keeps its result
// until it is taken. in_stall rises only when all six stages are full and
// out_stall is high.
// Reset clears every valid bit and the blend enable register.
`include "bilinear_sample_alpha_blend_core_macros.svh"

module bilinear_sample_alpha_blend_core
	import bsab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] src_top_left,
	input  logic [31:0] src_top_right,
	input  logic [31:0] src_bottom_left,
	input  logic [31:0] src_bottom_right,
	input  logic [7:0]  frac_x,
	input  logic [7:0]  frac_y,
	input  logic [31:0] dest_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_pixel,
	output logic        write_enable
);

	// Configuration register.
	logic blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 1'b0;
		end else if (cfg_wr_en) begin
			blend_q <= cfg_wr_data;
		end
	end

	// Valid bits and hold signals for every stage.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic hold_s1, hold_s2, hold_s3, hold_s4, hold_s5, hold_s6;

	// A stage holds when it is full and the stage after it holds.
	always_comb begin
		hold_s6 = valid_s6 && out_stall;
		hold_s5 = valid_s5 && hold_s6;
		hold_s4 = valid_s4 && hold_s5;
		hold_s3 = valid_s3 && hold_s4;
		hold_s2 = valid_s2 && hold_s3;
		hold_s1 = valid_s1 && hold_s2;
	end

	assign in_stall = hold_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (!hold_s1) valid_s1 <= in_valid;
			if (!hold_s2) valid_s2 <= valid_s1;
			if (!hold_s3) valid_s3 <= valid_s2;
			if (!hold_s4) valid_s4 <= valid_s3;
			if (!hold_s5) valid_s5 <= valid_s4;
			if (!hold_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: corner weights from the two fractions.
	logic [8:0]  wx0, wx1, wy0, wy1;
	logic [17:0] wfull [NUM_CORNERS];

	always_comb begin
		wx0 = WEIGHT_ONE - {1'b0, frac_x};
		wx1 = {1'b0, frac_x};
		wy0 = WEIGHT_ONE - {1'b0, frac_y};
		wy1 = {1'b0, frac_y};
		wfull[CORNER_TL] = 18'(wx0) * 18'(wy0);
		wfull[CORNER_TR] = 18'(wx1) * 18'(wy0);
		wfull[CORNER_BL] = 18'(wx0) * 18'(wy1);
		wfull[CORNER_BR] = 18'(wx1) * 18'(wy1);
	end

	pixel_t  px_s1 [NUM_CORNERS];
	weight_t w_s1  [NUM_CORNERS];
	pixel_t  dest_s1;
	logic    blend_s1;

	always_ff @(posedge clk) begin
		if (!hold_s1) begin
			px_s1[CORNER_TL] <= src_top_left;
			px_s1[CORNER_TR] <= src_top_right;
			px_s1[CORNER_BL] <= src_bottom_left;
			px_s1[CORNER_BR] <= src_bottom_right;
			for (int c = 0; c < NUM_CORNERS; c++) begin
				w_s1[c] <= wfull[c][WEIGHT_W-1:0];
			end
			dest_s1  <= dest_pixel;
			blend_s1 <= blend_q;
		end
	end

	// Stage 2: each byte lane of each corner times its corner weight.
	prod_t prod_d [NUM_CORNERS][NUM_LANES];

	always_comb begin
		logic [24:0] full;
		full = '0;
		for (int c = 0; c < NUM_CORNERS; c++) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				full = 25'(px_s1[c][CHAN_W*l +: CHAN_W]) * 25'(w_s1[c]);
				prod_d[c][l] = full[PROD_W-1:0];
			end
		end
	end

	prod_t  prod_s2 [NUM_CORNERS][NUM_LANES];
	pixel_t dest_s2;
	logic   blend_s2;

	always_ff @(posedge clk) begin
		if (!hold_s2) begin
			prod_s2  <= prod_d;
			dest_s2  <= dest_s1;
			blend_s2 <= blend_s1;
		end
	end

	// Stage 3: sum the four corners per lane and drop the 16 fraction bits.
	chan_t ch_d [NUM_LANES];

	always_comb begin
		prod_t sum;
		sum = '0;
		for (int l = 0; l < NUM_LANES; l++) begin
			sum = prod_s2[CORNER_TL][l] + prod_s2[CORNER_TR][l] +
			      prod_s2[CORNER_BL][l] + prod_s2[CORNER_BR][l];
			ch_d[l] = sum[PROD_W-1 -: CHAN_W];
		end
	end

	chan_t  ch_s3 [NUM_LANES];
	pixel_t dest_s3;
	logic   blend_s3;

	always_ff @(posedge clk) begin
		if (!hold_s3) begin
			ch_s3    <= ch_d;
			dest_s3  <= dest_s2;
			blend_s3 <= blend_s2;
		end
	end

	// Stage 4: pick the outcome from the blend enable and alpha and scale the destination colors.
	blend_mode_t mode_d;
	chan_t       inv_alpha;
	dprod_t      dprod_d [NUM_COLORS];

	always_comb begin
		if (!blend_s3) begin
			mode_d = MODE_COPY;
		end else if (ch_s3[LANE_ALPHA] == '0) begin
			mode_d = MODE_KEEP;
		end else if (ch_s3[LANE_ALPHA] == CHAN_MAX) begin
			mode_d = MODE_COPY;
		end else begin
			mode_d = MODE_BLEND;
		end
		inv_alpha = CHAN_MAX - ch_s3[LANE_ALPHA];
		for (int l = 0; l < NUM_COLORS; l++) begin
			dprod_d[l] = DPROD_W'(dest_s3[CHAN_W*l +: CHAN_W]) * DPROD_W'(inv_alpha);
		end
	end

	blend_mode_t mode_s4;
	chan_t       ch_s4 [NUM_COLORS];
	dprod_t      dprod_s4 [NUM_COLORS];
	pixel_t      dest_s4;

	always_ff @(posedge clk) begin
		if (!hold_s4) begin
			mode_s4  <= mode_d;
			for (int l = 0; l < NUM_COLORS; l++) begin
				ch_s4[l] <= ch_s3[l];
			end
			dprod_s4 <= dprod_d;
			dest_s4  <= dest_s3;
		end
	end

	// Stage 5: reciprocal multiply for the divide by 255.
	qmul_t qmul_d [NUM_COLORS];

	always_comb begin
		for (int l = 0; l < NUM_COLORS; l++) begin
			qmul_d[l] = QMUL_W'(dprod_s4[l]) * QMUL_W'(RECIP_255);
		end
	end

	blend_mode_t mode_s5;
	chan_t       ch_s5 [NUM_COLORS];
	qmul_t       qmul_s5 [NUM_COLORS];
	pixel_t      dest_s5;

	always_ff @(posedge clk) begin
		if (!hold_s5) begin
			mode_s5 <= mode_s4;
			ch_s5   <= ch_s4;
			qmul_s5 <= qmul_d;
			dest_s5 <= dest_s4;
		end
	end

	// Stage 6: add, saturate and select the written pixel.
	pixel_t pixel_d;
	logic   we_d;

	always_comb begin
		logic [CHAN_W:0] sum9;
		chan_t           blended [NUM_COLORS];
		sum9 = '0;
		for (int l = 0; l < NUM_COLORS; l++) begin
			sum9 = {1'b0, ch_s5[l]} + {1'b0, qmul_s5[l][RECIP_SHIFT +: CHAN_W]};
			blended[l] = sum9[CHAN_W] ? CHAN_MAX : sum9[CHAN_W-1:0];
		end
		unique case (mode_s5)
			MODE_KEEP: begin
				pixel_d = dest_s5;
				we_d    = 1'b0;
			end
			MODE_BLEND: begin
				pixel_d = {CHAN_MAX, blended[2], blended[1], blended[0]};
				we_d    = 1'b1;
			end
			default: begin
				pixel_d = {CHAN_MAX, ch_s5[2], ch_s5[1], ch_s5[0]};
				we_d    = 1'b1;
			end
		endcase
	end

	pixel_t pixel_s6;
	logic   we_s6;

	always_ff @(posedge clk) begin
		if (!hold_s6) begin
			pixel_s6 <= pixel_d;
			we_s6    <= we_d;
		end
	end

	assign out_valid    = valid_s6;
	assign out_pixel    = pixel_s6;
	assign write_enable = we_s6;

	// The four corner weights always add up to one in 1/65536 units.
	`BSAB_ASSERT_IMPL(a_weight_sum, clk, arst_n, valid_s1,
		(19'(w_s1[0]) + 19'(w_s1[1]) + 19'(w_s1[2]) + 19'(w_s1[3])) == WEIGHT_SUM,
		"corner weights do not sum to 65536")

	// A written pixel is always opaque.
	`BSAB_ASSERT_IMPL(a_opaque_write, clk, arst_n, out_valid && write_enable,
		out_pixel[PIXEL_W-1 -: CHAN_W] == CHAN_MAX, "written pixel is not opaque")

	// The input side is held back only when the whole pipe is full and stalled.
	`BSAB_ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall,
		out_valid && out_stall && valid_s1 && valid_s5, "input stalled with room in the pipe")

	// A result that leaves stage five is never dropped before the output.
	`BSAB_ASSERT_NEXT(a_s5_moves, clk, arst_n, valid_s5 && !hold_s5, valid_s6,
		"stage five result lost")

endmodule
